// ===== rtl/lcbs_pkg.sv =====
// Shared types and constants for the LED channel blink scheduler.
`default_nettype none

package lcbs_pkg;

    // fixed field widths
    localparam int REQ_W    = 2;
    localparam int BYTE_W   = 8;
    localparam int BOARD_W  = 3;
    localparam int LED_W    = 40;
    localparam int PHASE_W  = 10;
    localparam int PRESC_W  = 16;

    // phase counter wraps at this value
    localparam logic [PHASE_W-1:0] PHASE_LAST = 10'd839;

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_CONFIG = 2'd0,
        REQ_ENABLE = 2'd1,
        REQ_TICK   = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req;

    // controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_DRAIN,
        S_EMIT
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic               rd;        // read table entry at sweep address
        logic               wr_cfg;    // write mode/offset/period of addressed channel
        logic               wr_en;     // write enable bit of addressed channel
        logic               clr_wr;    // write reset entry at sweep address
        logic               clr_cnt;   // zero phase and prescale counters
        logic               emit;      // register board result, step prescaler
        logic [BOARD_W-1:0] board;
        logic               last;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic pipe_busy;   // lit pipeline still holds a channel
        logic num_ok;      // channel number addresses the table
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/lcbs_dp.sv =====
// Datapath: channel table memories, lit pipeline, counters and result register.
`default_nettype none

module lcbs_dp #(
    parameter int BOARDS             = 4,
    parameter int CHANNELS_PER_BOARD = 40,
    localparam int TABLE = BOARDS * CHANNELS_PER_BOARD,
    localparam int AW    = (TABLE > 1) ? $clog2(TABLE) : 1
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire lcbs_pkg::t_dp_cmd                   i_cmd,
    input  wire logic [AW-1:0]                       i_addr,
    input  wire logic [lcbs_pkg::BYTE_W-1:0]         i_channel_number,
    input  wire logic [lcbs_pkg::BYTE_W-1:0]         i_blink_mode,
    input  wire logic [lcbs_pkg::BYTE_W-1:0]         i_phase_offset,
    input  wire logic [lcbs_pkg::BYTE_W-1:0]         i_blink_period,
    input  wire logic [lcbs_pkg::BYTE_W-1:0]         i_enable_flag,
    input  wire logic                                i_cfg_valid,
    input  wire logic [lcbs_pkg::PRESC_W-1:0]        i_cfg_data,
    output lcbs_pkg::t_dp_sts                        o_sts,
    output logic                                     o_strobe,
    output logic [lcbs_pkg::BOARD_W-1:0]             o_board_index,
    output logic [lcbs_pkg::LED_W-1:0]               o_led_bits,
    output logic                                     o_last_board
);

    localparam int CW = 1 + 2 * lcbs_pkg::BYTE_W;   // blink, offset, period

    // five restoring-division steps of the remainder
    function automatic logic [7:0] mod_step5(input logic [7:0] rem_in,
                                              input logic [4:0] bits,
                                              input logic [7:0] per);
        logic [8:0] t;
        logic [7:0] rem;
        rem = rem_in;
        for (int i = 4; i >= 0; i--) begin
            t = {rem, bits[i]};
            if (t >= {1'b0, per}) begin
                t = t - {1'b0, per};
            end
            rem = t[7:0];
        end
        return rem;
    endfunction

    // table memories
    logic [CW-1:0] r_cfg_mem [TABLE];
    logic          r_en_mem  [TABLE];
    logic [CW-1:0] r_cfg_q;
    logic          r_en_q;

    // counters and limit
    logic [lcbs_pkg::PHASE_W-1:0] r_phase;
    logic [lcbs_pkg::PRESC_W-1:0] r_presc;
    logic [lcbs_pkg::PRESC_W-1:0] r_limit;
    logic [lcbs_pkg::PRESC_W-1:0] n_presc_inc;

    // pipeline
    logic       r_v0, r_v1;
    logic       r_s1_fix, r_s1_mod;
    logic [7:0] r_s1_rem, r_s1_per;
    logic [4:0] r_s1_low;
    logic [CHANNELS_PER_BOARD-1:0] r_bits, n_bits;

    // write address from the 1-based channel number
    logic [8:0]    w_num_m1;
    logic [AW-1:0] w_waddr;
    logic [AW-1:0] w_maddr;
    logic [CW-1:0] w_cfg_wdata;
    logic          w_en_wdata;

    assign w_num_m1      = {1'b0, i_channel_number} - 9'd1;
    assign w_waddr       = AW'(w_num_m1);
    assign o_sts.num_ok  = (i_channel_number != '0)
                        && ({24'd0, i_channel_number} <= 32'(TABLE));
    assign o_sts.pipe_busy = r_v0 | r_v1;

    assign w_maddr     = i_cmd.clr_wr ? i_addr : w_waddr;
    assign w_cfg_wdata = i_cmd.clr_wr ? '0
                       : {(|i_blink_mode), i_phase_offset, i_blink_period};
    assign w_en_wdata  = i_cmd.clr_wr ? 1'b0 : (|i_enable_flag);

    // settings memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_cfg || i_cmd.clr_wr) begin
            r_cfg_mem[w_maddr] <= w_cfg_wdata;
        end
        if (i_cmd.rd) begin
            r_cfg_q <= r_cfg_mem[i_addr];
        end
    end

    // enable memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en || i_cmd.clr_wr) begin
            r_en_mem[w_maddr] <= w_en_wdata;
        end
        if (i_cmd.rd) begin
            r_en_q <= r_en_mem[i_addr];
        end
    end

    // stage 1: distance to offset, classify, first half of the modulo
    logic [lcbs_pkg::PHASE_W-1:0] w_off, w_diff;
    logic       w_blink;
    logic [7:0] w_per;
    logic       w_fix, w_mod;

    assign w_blink = r_cfg_q[CW-1];
    assign w_off   = {2'b00, r_cfg_q[15:8]};
    assign w_per   = r_cfg_q[7:0];
    assign w_diff  = (r_phase >= w_off) ? (r_phase - w_off) : (w_off - r_phase);

    always_comb begin
        w_fix = 1'b0;
        w_mod = 1'b0;
        if (r_en_q) begin
            if (!w_blink) begin
                w_fix = 1'b1;
            end else if (w_per != 8'd0) begin
                w_mod = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_fix <= w_fix;
        r_s1_mod <= w_mod;
        r_s1_rem <= mod_step5(8'd0, w_diff[9:5], w_per);
        r_s1_low <= w_diff[4:0];
        r_s1_per <= w_per;
    end

    // stage 2: second half of the modulo, shift lit bit into the board vector
    logic       w_lit;
    logic [7:0] w_rem;

    assign w_rem = mod_step5(r_s1_rem, r_s1_low, r_s1_per);
    assign w_lit = r_s1_mod ? (w_rem == 8'd0) : r_s1_fix;

    always_comb begin
        n_bits = r_bits >> 1;
        n_bits[CHANNELS_PER_BOARD-1] = w_lit;
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_bits <= n_bits;
        end
    end

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= i_cmd.rd;
            r_v1 <= r_v0;
        end
    end

    // prescaler and phase counter
    assign n_presc_inc = r_presc + 16'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_cnt) begin
            r_phase <= '0;
            r_presc <= '0;
        end else if (i_cmd.emit) begin
            if (n_presc_inc == r_limit) begin
                r_presc <= '0;
                r_phase <= (r_phase == lcbs_pkg::PHASE_LAST) ? '0 : r_phase + 10'd1;
            end else begin
                r_presc <= n_presc_inc;
            end
        end
    end

    // prescale limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= 16'd1;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_board_index <= i_cmd.board;
            o_led_bits    <= lcbs_pkg::LED_W'(r_bits);
            o_last_board  <= i_cmd.last;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lcbs_ctrl.sv =====
// Controller: state machine sequencing clear sweeps, table writes and board walks.
`default_nettype none

module lcbs_ctrl #(
    parameter int BOARDS             = 4,
    parameter int CHANNELS_PER_BOARD = 40,
    localparam int TABLE = BOARDS * CHANNELS_PER_BOARD,
    localparam int AW    = (TABLE > 1) ? $clog2(TABLE) : 1,
    localparam int CHW   = (CHANNELS_PER_BOARD > 1) ? $clog2(CHANNELS_PER_BOARD) : 1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    input  wire logic [lcbs_pkg::REQ_W-1:0]    i_req_type,
    input  wire lcbs_pkg::t_dp_sts             i_sts,
    output lcbs_pkg::t_dp_cmd                  o_cmd,
    output logic [AW-1:0]                      o_addr,
    output logic                               busy
);

    lcbs_pkg::t_state r_state, n_state;
    lcbs_pkg::t_req   w_req;
    logic [AW-1:0]                 r_addr, n_addr, w_addr_inc;
    logic [CHW-1:0]                r_chan, n_chan;
    logic [lcbs_pkg::BOARD_W-1:0]  r_board, n_board;
    logic                          w_addr_end, w_chan_end, w_board_end;

    assign w_req       = lcbs_pkg::t_req'(i_req_type);
    assign w_addr_end  = (r_addr == AW'(TABLE - 1));
    assign w_addr_inc  = w_addr_end ? '0 : r_addr + AW'(1);
    assign w_chan_end  = (r_chan == CHW'(CHANNELS_PER_BOARD - 1));
    assign w_board_end = (r_board == lcbs_pkg::BOARD_W'(BOARDS - 1));
    assign busy        = (r_state != lcbs_pkg::S_IDLE);
    assign o_addr      = r_addr;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lcbs_pkg::S_CLEAR: begin
                if (w_addr_end) n_state = lcbs_pkg::S_IDLE;
            end
            lcbs_pkg::S_IDLE: begin
                if (start && w_req == lcbs_pkg::REQ_TICK) begin
                    n_state = lcbs_pkg::S_READ;
                end else if (start && w_req == lcbs_pkg::REQ_CLEAR) begin
                    n_state = lcbs_pkg::S_CLEAR;
                end
            end
            lcbs_pkg::S_READ: begin
                if (w_chan_end) n_state = lcbs_pkg::S_DRAIN;
            end
            lcbs_pkg::S_DRAIN: begin
                if (!i_sts.pipe_busy) n_state = lcbs_pkg::S_EMIT;
            end
            lcbs_pkg::S_EMIT: begin
                n_state = w_board_end ? lcbs_pkg::S_IDLE : lcbs_pkg::S_READ;
            end
            default: n_state = lcbs_pkg::S_IDLE;
        endcase
    end

    // commands to the datapath
    always_comb begin
        o_cmd       = '0;
        o_cmd.board = r_board;
        o_cmd.last  = w_board_end;
        unique case (r_state)
            lcbs_pkg::S_CLEAR: o_cmd.clr_wr = 1'b1;
            lcbs_pkg::S_IDLE: begin
                if (start) begin
                    unique case (w_req)
                        lcbs_pkg::REQ_CONFIG: o_cmd.wr_cfg  = i_sts.num_ok;
                        lcbs_pkg::REQ_ENABLE: o_cmd.wr_en   = i_sts.num_ok;
                        lcbs_pkg::REQ_CLEAR:  o_cmd.clr_cnt = 1'b1;
                        lcbs_pkg::REQ_TICK:   o_cmd.clr_cnt = 1'b0;
                        default:              o_cmd.clr_cnt = 1'b0;
                    endcase
                end
            end
            lcbs_pkg::S_READ:  o_cmd.rd   = 1'b1;
            lcbs_pkg::S_DRAIN: o_cmd.rd   = 1'b0;
            lcbs_pkg::S_EMIT:  o_cmd.emit = 1'b1;
            default:           o_cmd.rd   = 1'b0;
        endcase
    end

    // sweep address, channel and board counters
    always_comb begin
        n_addr  = r_addr;
        n_chan  = r_chan;
        n_board = r_board;
        case (r_state)
            lcbs_pkg::S_CLEAR: n_addr = w_addr_inc;
            lcbs_pkg::S_READ: begin
                n_addr = w_addr_inc;
                n_chan = w_chan_end ? '0 : r_chan + CHW'(1);
            end
            lcbs_pkg::S_EMIT: begin
                n_board = w_board_end ? '0 : r_board + lcbs_pkg::BOARD_W'(1);
            end
            default: n_addr = r_addr;
        endcase
    end

    // state and counter registers; reset starts with a clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lcbs_pkg::S_CLEAR;
            r_addr  <= '0;
            r_chan  <= '0;
            r_board <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_chan  <= n_chan;
            r_board <= n_board;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/led_channel_blink_scheduler.sv =====
// Top level of the LED channel blink scheduler: controller plus datapath.
// Configure and enable requests complete without raising busy.
// Tick: busy while the boards are walked in turn, one entry read a cycle in S_READ, pausing in
// S_DRAIN and S_EMIT after each board; each board strobes its result in the cycle after S_EMIT.
// Clear: busy for a pass over every table entry; synchronous reset runs the same pass first.
// Results cannot be stalled by the receiver; the limit register port is always ready.
`default_nettype none

module led_channel_blink_scheduler #(
    parameter int BOARDS             = 4,
    parameter int CHANNELS_PER_BOARD = 40
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [lcbs_pkg::REQ_W-1:0]          i_req_type,
    input  wire logic [lcbs_pkg::BYTE_W-1:0]         i_channel_number,
    input  wire logic [lcbs_pkg::BYTE_W-1:0]         i_blink_mode,
    input  wire logic [lcbs_pkg::BYTE_W-1:0]         i_phase_offset,
    input  wire logic [lcbs_pkg::BYTE_W-1:0]         i_blink_period,
    input  wire logic [lcbs_pkg::BYTE_W-1:0]         i_enable_flag,
    output logic                                     o_strobe,
    output logic [lcbs_pkg::BOARD_W-1:0]             o_board_index,
    output logic [lcbs_pkg::LED_W-1:0]               o_led_bits,
    output logic                                     o_last_board,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [lcbs_pkg::PRESC_W-1:0]        i_cfg_data
);

    localparam int TABLE = BOARDS * CHANNELS_PER_BOARD;
    localparam int AW    = (TABLE > 1) ? $clog2(TABLE) : 1;

    lcbs_pkg::t_dp_cmd w_cmd;
    lcbs_pkg::t_dp_sts w_sts;
    logic [AW-1:0]     w_addr;

    assign o_cfg_ready = 1'b1;

    lcbs_ctrl #(
        .BOARDS             (BOARDS),
        .CHANNELS_PER_BOARD (CHANNELS_PER_BOARD)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req_type (i_req_type),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_addr     (w_addr),
        .busy       (busy)
    );

    lcbs_dp #(
        .BOARDS             (BOARDS),
        .CHANNELS_PER_BOARD (CHANNELS_PER_BOARD)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_addr           (w_addr),
        .i_channel_number (i_channel_number),
        .i_blink_mode     (i_blink_mode),
        .i_phase_offset   (i_phase_offset),
        .i_blink_period   (i_blink_period),
        .i_enable_flag    (i_enable_flag),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .o_sts            (w_sts),
        .o_strobe         (o_strobe),
        .o_board_index    (o_board_index),
        .o_led_bits       (o_led_bits),
        .o_last_board     (o_last_board)
    );

endmodule

`default_nettype wire
